### hdl/bra_pkg.sv
`default_nettype none

package bra_pkg;

   localparam int MAP_BYTES_DEFAULT = 512;

   localparam int          INDEX_W     = 12;
   localparam int          RUN_W       = 13;
   localparam int          BYTES_USE_W = 10;
   localparam logic [9:0]  BYTES_IN_USE_RESET = 10'd512;

   // Register index taken from paddr[2]
   localparam logic REG_BYTES_IN_USE = 1'b0;

   typedef enum logic [1:0] {
      CMD_SCAN  = 2'd0,
      CMD_SET   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_TEST  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_WIPE,
      ST_IDLE,
      ST_BIT,
      ST_SCAN
   } state_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [INDEX_W-1:0]   index;
      logic [RUN_W-1:0]     run_length;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [INDEX_W-1:0]   start_index;
      logic                 bit_value;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/bitmap_run_allocator.sv
`default_nettype none

// First-fit allocator over a bitmap of MapBytes bytes of allocation marks.
// Commands arrive on req_payload and are taken at a clock edge with start
// high and busy low. Each command gives exactly one result beat on
// rsp_payload, marked by rsp_strobe for a single cycle; the receiver must
// take it then, there is no back-pressure.
//   set / clear / test: one mark byte is read from the store, then written
//   back or inspected; rsp_strobe is registered from the ST_BIT state, and
//   the block is back in idle when it rises.
//   scan: the store is walked one byte per cycle from byte 0, counting clear
//   bits; the result beat follows the last byte examined (the byte holding
//   the end of the run, or every byte in use on failure). An empty region
//   answers straight from idle, with no scan.
// The walk through the single-port-read mark memory sets the scan time.
// busy is already low while the result beat is presented, so a new command
// may be taken at the edge that ends it; an empty-region scan keeps busy low.
// Reset (synchronous) starts a wipe pass that zeroes the mark store, one
// byte per cycle, across all MapBytes bytes; busy stays high meanwhile. The
// bytes_in_use register (APB, address 0) is reset to 512 and may be written
// at any time the block is idle.

module bitmap_run_allocator #(
   parameter int MapBytes = bra_pkg::MAP_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire bra_pkg::req_type req_payload,
   output      logic             rsp_strobe,
   output      bra_pkg::rsp_type rsp_payload,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output      logic [31:0]      prdata,
   output      logic             pready
);

   import bra_pkg::*;

   localparam int AW        = (MapBytes > 1) ? $clog2(MapBytes) : 1;
   localparam int CW        = $clog2(MapBytes + 1);
   localparam int TotalBits = MapBytes * 8;

   state_type               state_ff, state_in;
   logic [AW-1:0]           wipe_ff, wipe_in;
   logic [AW-1:0]           byte_ff, byte_in;
   logic [RUN_W-1:0]        cnt_ff, cnt_in;
   logic [RUN_W-1:0]        want_ff, want_in;
   logic [INDEX_W-1:0]      run_start_ff, run_start_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [INDEX_W-1:0]      index_ff, index_in;
   logic                    in_range_ff, in_range_in;
   logic [BYTES_USE_W-1:0]  bytes_in_use_ff;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [7:0]              ram_wr_data;
   logic [AW-1:0]           ram_rd_addr;
   logic [7:0]              ram_rd_data;

   logic [CW-1:0]           nbytes;
   logic                    accept;
   logic                    last_byte;
   logic                    hit;
   logic [RUN_W-1:0]        scan_cnt;
   logic [INDEX_W-1:0]      scan_start;

   bra_ram #(
      .Width (8),
      .Depth (MapBytes),
      .AddrW (AW)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_BYTES_IN_USE) ? 32'(bytes_in_use_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_in_use_ff <= BYTES_IN_USE_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_BYTES_IN_USE) begin
         bytes_in_use_ff <= pwdata[BYTES_USE_W-1:0];
      end
   end

   assign nbytes = (32'(bytes_in_use_ff) > MapBytes) ? CW'(MapBytes) : CW'(bytes_in_use_ff);
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign last_byte = (CW'(byte_ff) == nbytes - CW'(1));

   // Run counting across the eight bits of the byte just read
   always_comb begin
      scan_cnt   = cnt_ff;
      scan_start = run_start_ff;
      hit        = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (!hit) begin
            if (ram_rd_data[b]) begin
               scan_cnt   = '0;
               scan_start = INDEX_W'({byte_ff, 3'(b)} + 1'b1);
            end else begin
               scan_cnt = scan_cnt + RUN_W'(1);
               if (scan_cnt == want_ff) begin
                  hit = 1'b1;
               end
            end
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WIPE: begin
            if (wipe_ff == AW'(MapBytes - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.cmd != CMD_SCAN) begin
                  state_in = ST_BIT;
               end else if (nbytes != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_BIT: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (hit || last_byte) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      wipe_in       = wipe_ff;
      byte_in       = byte_ff;
      cnt_in        = cnt_ff;
      want_in       = want_ff;
      run_start_in  = run_start_ff;
      cmd_in        = cmd_ff;
      index_in      = index_ff;
      in_range_in   = in_range_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(index_ff >> 3);
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = AW'(req_payload.index >> 3);

      unique case (state_ff)
         ST_WIPE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wipe_ff;
            ram_wr_data = 8'h00;
            wipe_in     = wipe_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in       = req_payload.cmd;
               index_in     = req_payload.index;
               in_range_in  = (32'(req_payload.index) < TotalBits);
               want_in      = (req_payload.run_length == '0) ? RUN_W'(1)
                                                            : req_payload.run_length;
               byte_in      = '0;
               cnt_in       = '0;
               run_start_in = '0;
               if (req_payload.cmd == CMD_SCAN) begin
                  ram_rd_addr = '0;
                  if (nbytes == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{found: 1'b0, start_index: '0, bit_value: 1'b0};
                  end
               end
            end
         end
         ST_BIT: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '{found: 1'b1, start_index: '0, bit_value: 1'b0};
            unique case (cmd_ff)
               CMD_SET: begin
                  ram_wr_en = in_range_ff;
                  ram_wr_data[index_ff[2:0]] = 1'b1;
               end
               CMD_CLEAR: begin
                  ram_wr_en = in_range_ff;
                  ram_wr_data[index_ff[2:0]] = 1'b0;
               end
               CMD_TEST: begin
                  rsp_in.bit_value = in_range_ff & ram_rd_data[index_ff[2:0]];
               end
               default: begin
                  ram_wr_en = 1'b0;
               end
            endcase
         end
         ST_SCAN: begin
            // Fetch the following byte while this one is counted
            ram_rd_addr  = byte_ff + AW'(1);
            byte_in      = byte_ff + AW'(1);
            cnt_in       = scan_cnt;
            run_start_in = scan_start;
            if (hit) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{found: 1'b1, start_index: scan_start, bit_value: 1'b0};
            end else if (last_byte) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{found: 1'b0, start_index: '0, bit_value: 1'b0};
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WIPE;
         wipe_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wipe_ff       <= wipe_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      cnt_ff       <= cnt_in;
      want_ff      <= want_in;
      run_start_ff <= run_start_in;
      cmd_ff       <= cmd_in;
      index_ff     <= index_in;
      in_range_ff  <= in_range_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### hdl/bra_ram.sv
`default_nettype none

module bra_ram #(
   parameter int Width = 8,
   parameter int Depth = 512,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output      logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### test/tb_bitmap_run_allocator.sv
`timescale 1ns / 1ps

module tb_bitmap_run_allocator;
   import bra_pkg::*;

   localparam int MAP_BYTES      = MAP_BYTES_DEFAULT;
   localparam int MAP_BITS       = MAP_BYTES * 8;
   localparam logic [7:0] FULL_BYTE = 8'hff;
   localparam int ITEM_TARGET    = 1950;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 600;
   localparam int MAX_REPORTS    = 10;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   req_type     req_payload = '0;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [2:0]  paddr       = '0;
   logic [31:0] pwdata      = '0;
   logic        busy;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic [31:0] prdata;
   logic        pready;

   // Shadow of the block: mark bitmap and region size
   logic [7:0]  marks [MAP_BYTES];
   logic [9:0]  region_bytes;

   rsp_type     expected_beats [$];
   int          items_sent     = 0;
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;
   int          burst_left     = 0;

   typedef struct {
      bit         cfg;
      logic [9:0] cfg_value;
      req_type    req;
      bit         typed;
      rsp_type    want;
   } table_row_type;

   table_row_type directed_rows [$];

   bitmap_run_allocator #(
      .MapBytes(MAP_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #6 clock = ~clock;

   function automatic logic mark_at(int pos);
      if (pos >= MAP_BITS) return 1'b0;
      return marks[pos >> 3][pos & 7];
   endfunction

   // First-fit search and single-mark commands, applied to the shadow bitmap
   function automatic rsp_type alloc_predict(req_type r);
      rsp_type o;
      int nb, bp, first, want, count, pos;
      o = '0;
      o.found = 1'b1;
      case (r.cmd)
         CMD_SCAN: begin
            nb = (region_bytes > MAP_BYTES) ? MAP_BYTES : int'(region_bytes);
            bp = 0;
            while (bp < nb && marks[bp] == FULL_BYTE) bp++;
            o.found = 1'b0;
            if (bp < nb) begin
               first = bp * 8;
               while (mark_at(first)) first++;
               want = int'(r.run_length);
               if (want <= 1) begin
                  o.found = 1'b1;
                  o.start_index = first[11:0];
               end else begin
                  count = 1;
                  for (pos = first + 1; pos < nb * 8 && !o.found; pos++) begin
                     if (mark_at(pos)) count = 0;
                     else count++;
                     if (count == want) begin
                        o.found = 1'b1;
                        o.start_index = 12'(pos + 1 - count);
                     end
                  end
               end
            end
         end
         CMD_SET:   marks[r.index[11:3]][r.index[2:0]] = 1'b1;
         CMD_CLEAR: marks[r.index[11:3]][r.index[2:0]] = 1'b0;
         default:   o.bit_value = mark_at(int'(r.index));
      endcase
      return o;
   endfunction

   function automatic void add_item(cmd_type c, int idx, int len, bit typed,
                                    bit f, int si, bit bv);
      table_row_type row;
      row.cfg              = 1'b0;
      row.cfg_value        = '0;
      row.req.cmd          = c;
      row.req.index        = idx[11:0];
      row.req.run_length   = len[12:0];
      row.typed            = typed;
      row.want.found       = f;
      row.want.start_index = si[11:0];
      row.want.bit_value   = bv;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_cfg(int v);
      table_row_type row;
      row.cfg       = 1'b1;
      row.cfg_value = v[9:0];
      row.req       = '0;
      row.typed     = 1'b0;
      row.want      = '0;
      directed_rows.push_back(row);
   endfunction

   task automatic send_item(input req_type r, input bit typed, input rsp_type want);
      int gap;
      rsp_type predicted;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
      burst_left--;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      predicted = alloc_predict(r);
      expected_beats.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Region size may only change once the block has drained
   task automatic write_bytes_in_use(input logic [9:0] v);
      start <= 1'b0;
      while (expected_beats.size() != 0 || busy) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_BYTES_IN_USE, 2'b00};
      pwdata  <= {22'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      region_bytes = v;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat: found=%0b start=%0d bit=%0b",
                        rsp_payload.found, rsp_payload.start_index, rsp_payload.bit_value);
         end else begin
            automatic rsp_type want = expected_beats.pop_front();
            if (rsp_payload.found !== want.found ||
                rsp_payload.start_index !== want.start_index ||
                rsp_payload.bit_value !== want.bit_value) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"result mismatch: expected found=%0b start=%0d bit=%0b,",
                            " got found=%0b start=%0d bit=%0b"},
                           want.found, want.start_index, want.bit_value,
                           rsp_payload.found, rsp_payload.start_index,
                           rsp_payload.bit_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int n_phase, k, pick, eff, rb, base, len, idx, cfg_value;
      req_type r;
      rsp_type none;
      none = '0;
      for (k = 0; k < MAP_BYTES; k++) marks[k] = 8'h00;
      region_bytes = BYTES_IN_USE_RESET;

      // After reset: whole store clear, region at its widest
      add_item(CMD_TEST, 0, 0, 1, 1, 0, 0);
      add_item(CMD_SCAN, 0, 0, 1, 1, 0, 0);
      add_item(CMD_SCAN, 4095, 1, 1, 1, 0, 0);
      add_item(CMD_SCAN, 0, 4096, 1, 1, 0, 0);
      add_item(CMD_SCAN, 0, 4097, 1, 0, 0, 0);
      add_item(CMD_SCAN, 0, 8191, 1, 0, 0, 0);
      add_item(CMD_SET, 4095, 8191, 1, 1, 0, 0);
      add_item(CMD_TEST, 4095, 0, 1, 1, 0, 1);
      add_item(CMD_SCAN, 0, 4096, 1, 0, 0, 0);
      // Fill the single byte in use: the scan must fail
      add_cfg(1);
      for (k = 0; k < 8; k++) add_item(CMD_SET, k, 0, 1, 1, 0, 0);
      add_item(CMD_SCAN, 0, 1, 1, 0, 0, 0);
      // Run that would spill past the region
      add_cfg(2);
      add_item(CMD_SCAN, 0, 1, 0, 0, 0, 0);
      add_item(CMD_SCAN, 0, 8, 0, 0, 0, 0);
      add_item(CMD_SCAN, 0, 9, 1, 0, 0, 0);
      // Empty region, then an oversized one clamped to the store
      add_cfg(0);
      add_item(CMD_SCAN, 0, 1, 1, 0, 0, 0);
      add_cfg(1023);
      add_item(CMD_SCAN, 0, 4087, 0, 0, 0, 0);
      add_item(CMD_CLEAR, 3, 0, 1, 1, 0, 0);
      add_item(CMD_SCAN, 0, 1, 0, 0, 0, 0);
      add_item(CMD_TEST, 3, 0, 1, 1, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg) write_bytes_in_use(directed_rows[i].cfg_value);
         else send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) cfg_value = 1023;
         else if (pick < 8) cfg_value = $urandom_range(513, 1023);
         else if (pick < 14) cfg_value = 512;
         else if (pick < 18) cfg_value = 0;
         else if (pick < 26) cfg_value = 1;
         else cfg_value = $urandom_range(2, 24);
         write_bytes_in_use(cfg_value[9:0]);
         eff = (cfg_value == 0) ? 1 : ((cfg_value > MAP_BYTES) ? MAP_BYTES : cfg_value);
         rb = eff * 8;
         n_phase = $urandom_range(20, 80);
         for (k = 0; k < n_phase; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               // Mark a stretch of consecutive bits to build full bytes
               base = $urandom_range(0, eff - 1) * 8;
               len = $urandom_range(8, 40);
               for (idx = base; idx < base + len; idx++) begin
                  r.cmd        = CMD_SET;
                  r.index      = idx[11:0];
                  r.run_length = 13'($urandom);
                  send_item(r, 1'b0, none);
               end
            end else begin
               r.index      = 12'($urandom);
               r.run_length = 13'($urandom);
               if (pick < 38) r.cmd = CMD_SET;
               else if (pick < 53) r.cmd = CMD_CLEAR;
               else if (pick < 68) r.cmd = CMD_TEST;
               else r.cmd = CMD_SCAN;
               if (r.cmd != CMD_SCAN) begin
                  if ($urandom_range(0, 4) != 0) begin
                     if ($urandom_range(0, 1) == 0)
                        idx = $urandom_range(0, ((rb < 64) ? rb : 64) - 1);
                     else
                        idx = $urandom_range(0, rb - 1);
                     r.index = idx[11:0];
                  end
               end else begin
                  pick = $urandom_range(0, 99);
                  if (pick < 45) len = $urandom_range(1, 8);
                  else if (pick < 55) len = 0;
                  else if (pick < 80) len = $urandom_range(9, rb);
                  else if (pick < 90) len = $urandom_range(rb, rb + 16);
                  else len = int'(r.run_length);
                  r.run_length = len[12:0];
               end
               send_item(r, 1'b0, none);
            end
         end
      end

      start <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
hdl/bra_pkg.sv
hdl/bra_ram.sv
hdl/bitmap_run_allocator.sv
test/tb_bitmap_run_allocator.sv
